/* sv/rfo_pkg.sv */
// Shared types, codes and default sizes of the ring FIFO with overwrite.
package rfo_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 64;
  localparam int CNT_W    = 4;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;
  localparam int S_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;
  localparam int M_TUSER_W = STATUS_W + 1;

  localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_OW = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_CONT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ_WRAP = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PEEK      = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NODATA = 2'd2;

  typedef struct packed {
    logic                load;
    logic                use_mem;
    logic [STATUS_W-1:0] status;
    logic                dvalid;
    logic                last;
    logic [OCC_W-1:0]    occ;
  } res_t;

endpackage

/* sv/rfo_store.sv */
// Item memory: one write port, one read port with registered read data.
module rfo_store
  import rfo_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
  localparam int PW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [PW-1:0]         wr_addr_i,
  input  logic [ITEM_WIDTH-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [PW-1:0]         rd_addr_i,
  output logic [ITEM_WIDTH-1:0] rd_data_o
);

  logic [ITEM_WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* sv/rfo_seq.sv */
// Request sequencer: pointers, pop counter and result control.
module rfo_seq
  import rfo_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
  localparam int PW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [FUNC_W-1:0]     req_func_i,
  input  logic [ITEM_WIDTH-1:0] req_item_i,
  input  logic [CNT_W-1:0]      req_count_i,
  input  logic                  out_free_i,
  output res_t                  res_o,
  output logic                  wr_en_o,
  output logic [PW-1:0]         wr_addr_o,
  output logic [ITEM_WIDTH-1:0] wr_data_o,
  output logic                  rd_en_o,
  output logic [PW-1:0]         rd_addr_o
);

  localparam int CW = PW + 1;
  localparam int XW = (CW > CNT_W) ? CW : CNT_W;

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_DELIVER = 1'b1;

  logic             state_q, state_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [PW-1:0]    rp_q, rp_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             pop_q, pop_d;

  logic [PW-1:0]    fill;
  logic             full;
  logic             accept;
  logic [CW-1:0]    to_end;
  logic [CW-1:0]    lim_cont;
  logic [CW-1:0]    lim;
  logic [CNT_W-1:0] n;

  assign fill     = wp_q - rp_q;
  assign full     = (fill == PW'(DEPTH - 1));
  assign to_end   = CW'(DEPTH) - CW'(rp_q);
  assign lim_cont = (CW'(fill) < to_end) ? CW'(fill) : to_end;
  assign lim      = (req_func_i == FUNC_READ_CONT) ? lim_cont : CW'(fill);
  assign n        = (XW'(req_count_i) < XW'(lim)) ? req_count_i : CNT_W'(lim);

  assign req_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign accept      = req_valid_i && req_ready_o;
  assign wr_addr_o   = wp_q;
  assign wr_data_o   = req_item_i;

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    rem_d     = rem_q;
    pop_d     = pop_q;
    wr_en_o   = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = rp_q;
    res_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_func_i)
            FUNC_APPEND, FUNC_APPEND_OW: begin
              res_o.load = 1'b1;
              res_o.last = 1'b1;
              if (full && (req_func_i == FUNC_APPEND)) begin
                res_o.status = STAT_FULL;
                res_o.occ    = OCC_W'(fill);
              end else begin
                wr_en_o      = 1'b1;
                wp_d         = wp_q + PW'(1);
                rp_d         = full ? rp_q + PW'(1) : rp_q;
                res_o.status = STAT_OK;
                res_o.occ    = OCC_W'(full ? fill : fill + PW'(1));
              end
            end
            FUNC_READ_CONT, FUNC_READ_WRAP: begin
              if (n == '0) begin
                res_o.load   = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = STAT_NODATA;
                res_o.occ    = OCC_W'(fill);
              end else begin
                rd_en_o = 1'b1;
                rem_d   = n;
                pop_d   = 1'b1;
                state_d = ST_DELIVER;
              end
            end
            FUNC_PEEK: begin
              if (fill == '0) begin
                res_o.load   = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = STAT_NODATA;
                res_o.occ    = OCC_W'(fill);
              end else begin
                rd_en_o = 1'b1;
                rem_d   = CNT_W'(1);
                pop_d   = 1'b0;
                state_d = ST_DELIVER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DELIVER: begin
        if (out_free_i) begin
          res_o.load    = 1'b1;
          res_o.use_mem = 1'b1;
          res_o.status  = STAT_OK;
          res_o.dvalid  = 1'b1;
          res_o.last    = (rem_q == CNT_W'(1));
          if (pop_q) begin
            rp_d = rp_q + PW'(1);
          end
          res_o.occ = OCC_W'(wp_q - rp_d);
          rem_d     = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = rp_d;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      rem_q   <= '0;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      rem_q   <= rem_d;
      pop_q   <= pop_d;
    end
  end

endmodule

/* sv/ring_fifo_with_overwrite.sv */
// Ring FIFO with overwrite: top level with sequencer, item memory and output register.
// Appends, rejects and no-data results are written to the result register when the request is accepted.
// Reads and peeks first read the item memory, then emit one result per cycle while the output register is free.
// A new request is taken once the previous one has loaded its last result and the output register is free.
// Reset clears both pointers and the control state; the item memory is not cleared.
module ring_fifo_with_overwrite
  import rfo_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
  localparam int PW        = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // item_value, read_count
  input  logic [FUNC_W-1:0]    s_axis_tuser,  // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // data_value, occupancy
  output logic [M_TUSER_W-1:0] m_axis_tuser,  // status, data_valid
  output logic                 m_axis_tlast
);

  res_t                  res;
  logic                  out_free;
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic [ITEM_WIDTH-1:0] rd_data;
  logic signed [ITEM_WIDTH-1:0] rd_signed;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic                  dvalid_q;
  logic                  last_q;
  logic [OCC_W-1:0]      occ_q;
  logic [DATA_W-1:0]     data_q;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign rd_signed = rd_data;

  rfo_seq #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_func_i  (s_axis_tuser),
    .req_item_i  (s_axis_tdata[ITEM_WIDTH-1:0]),
    .req_count_i (s_axis_tdata[DATA_W +: CNT_W]),
    .out_free_i  (out_free),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  rfo_store #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      status_q <= res.status;
      dvalid_q <= res.dvalid;
      last_q   <= res.last;
      occ_q    <= res.occ;
      data_q   <= res.use_mem ? DATA_W'(rd_signed) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - DATA_W - OCC_W)'(0), occ_q, data_q};
  assign m_axis_tuser  = {dvalid_q, status_q};
  assign m_axis_tlast  = last_q;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the ring FIFO with overwrite: bursty requests, stalled results.
module testbench;
  import rfo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS     = 16;
  localparam int RANDOM_ITEMS   = 230;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic                has_item;
    logic                last;
    logic [OCC_W-1:0]    held;
  } fifo_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_e;
  typedef enum int {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_pace_e;

  class ring_fifo_tracker;
    logic [DATA_W-1:0] slot [RING_SLOTS];
    logic [3:0]        wr_ptr;
    logic [3:0]        rd_ptr;
    fifo_result_t      owed_results [$];
    int                faults;

    function new();
      wr_ptr = '0;
      rd_ptr = '0;
      faults = 0;
    endfunction

    function void owe(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] v, logic hv, logic lst);
      fifo_result_t r;
      r.status   = st;
      r.value    = v;
      r.has_item = hv;
      r.last     = lst;
      r.held     = 4'(wr_ptr - rd_ptr);
      owed_results.push_back(r);
    endfunction

    function void pop_run(int n);
      logic [DATA_W-1:0] v;
      if (n == 0) begin
        owe(STAT_NODATA, '0, 1'b0, 1'b1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        v = slot[rd_ptr];
        rd_ptr = rd_ptr + 4'd1;
        owe(STAT_OK, v, 1'b1, i == n - 1);
      end
    endfunction

    function void take_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v, logic [CNT_W-1:0] c);
      int held;
      int to_end;
      int n;
      held   = int'(4'(wr_ptr - rd_ptr));
      to_end = RING_SLOTS - int'(rd_ptr);
      case (f)
        FUNC_APPEND, FUNC_APPEND_OW: begin
          if (held == RING_SLOTS - 1 && f == FUNC_APPEND) begin
            owe(STAT_FULL, '0, 1'b0, 1'b1);
          end else begin
            if (held == RING_SLOTS - 1) rd_ptr = rd_ptr + 4'd1;
            slot[wr_ptr] = v;
            wr_ptr = wr_ptr + 4'd1;
            owe(STAT_OK, '0, 1'b0, 1'b1);
          end
        end
        FUNC_READ_CONT: begin
          n = held;
          if (to_end < n) n = to_end;
          if (int'(c) < n) n = int'(c);
          pop_run(n);
        end
        FUNC_READ_WRAP: begin
          n = held;
          if (int'(c) < n) n = int'(c);
          pop_run(n);
        end
        FUNC_PEEK: begin
          if (held == 0) owe(STAT_NODATA, '0, 1'b0, 1'b1);
          else owe(STAT_OK, slot[rd_ptr], 1'b1, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void match_result(logic [M_TDATA_W-1:0] td, logic [M_TUSER_W-1:0] tu, logic tl);
      fifo_result_t e;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%h last=%b", $time, td, tu, tl);
        faults++;
        return;
      end
      e = owed_results.pop_front();
      if (tu[STATUS_W-1:0] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, tu[STATUS_W-1:0]);
        faults++;
      end
      if (td[DATA_W-1:0] !== e.value) begin
        $display("%0t: data_value expected %h actual %h", $time, e.value, td[DATA_W-1:0]);
        faults++;
      end
      if (tu[STATUS_W] !== e.has_item) begin
        $display("%0t: data_valid expected %b actual %b", $time, e.has_item, tu[STATUS_W]);
        faults++;
      end
      if (tl !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, tl);
        faults++;
      end
      if (td[DATA_W+OCC_W-1:DATA_W] !== e.held) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, e.held,
                 td[DATA_W+OCC_W-1:DATA_W]);
        faults++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [FUNC_W-1:0]    s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  ring_fifo_tracker tracker = new();
  int       burst_left = 0;
  int       cycle_count = 0;
  int       pace_left = 0;
  rx_pace_e rx_pace = RX_OPEN;

  ring_fifo_with_overwrite DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tracker.take_request(s_axis_tuser, s_axis_tdata[DATA_W-1:0],
                           s_axis_tdata[DATA_W+CNT_W-1:DATA_W]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      rx_pace   <= rx_pace_e'($urandom_range(0, 2));
      pace_left <= $urandom_range(20, 80);
    end else begin
      pace_left <= pace_left - 1;
    end
    case (rx_pace)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
      default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return {1'b1, {(DATA_W-1){1'b0}}};
    if (roll == 1) return {1'b0, {(DATA_W-1){1'b1}}};
    if (roll == 2) return '0;
    if (roll == 3) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic push_request(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
                              input logic [CNT_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-DATA_W-CNT_W){1'b0}}, c, v};
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic run_random_traffic();
    traffic_mix_e     mix;
    int               seg_left;
    int               sent;
    int               roll;
    logic [FUNC_W-1:0] f;
    mix = MIX_EVEN;
    seg_left = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        mix = traffic_mix_e'($urandom_range(0, 2));
        seg_left = $urandom_range(15, 30);
      end
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL: begin
          if (roll < 45) f = FUNC_APPEND;
          else if (roll < 75) f = FUNC_APPEND_OW;
          else if (roll < 83) f = FUNC_READ_CONT;
          else if (roll < 90) f = FUNC_READ_WRAP;
          else if (roll < 97) f = FUNC_PEEK;
          else f = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        MIX_DRAIN: begin
          if (roll < 15) f = FUNC_APPEND;
          else if (roll < 25) f = FUNC_APPEND_OW;
          else if (roll < 55) f = FUNC_READ_CONT;
          else if (roll < 85) f = FUNC_READ_WRAP;
          else if (roll < 97) f = FUNC_PEEK;
          else f = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
        default: begin
          if (roll < 30) f = FUNC_APPEND;
          else if (roll < 45) f = FUNC_APPEND_OW;
          else if (roll < 62) f = FUNC_READ_CONT;
          else if (roll < 80) f = FUNC_READ_WRAP;
          else if (roll < 97) f = FUNC_PEEK;
          else f = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end
      endcase
      push_request(f, pick_value(), 4'($urandom_range(0, 15)));
      if (f <= FUNC_PEEK) begin
        sent++;
        seg_left--;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_request(FUNC_PEEK, '1, 4'd15);
    push_request(FUNC_READ_CONT, '1, 4'd15);
    push_request(FUNC_READ_WRAP, '0, 4'd15);
    push_request(FUNC_APPEND, {1'b1, {(DATA_W-1){1'b0}}}, 4'd0);
    push_request(FUNC_APPEND, {1'b0, {(DATA_W-1){1'b1}}}, 4'd15);
    push_request(FUNC_READ_WRAP, '1, 4'd0);
    push_request(FUNC_PEEK, '0, 4'd0);
    push_request(FUNC_READ_WRAP, '0, 4'd15);
    for (int i = 0; i < RING_SLOTS - 1; i++) begin
      push_request((i % 3 == 0) ? FUNC_APPEND_OW : FUNC_APPEND, pick_value(), 4'(i));
    end
    push_request(FUNC_APPEND, '1, 4'd0);
    push_request(FUNC_APPEND_OW, pick_value(), 4'd0);
    push_request(FUNC_SPARE_LAST, '1, 4'd15);
    push_request(FUNC_READ_CONT, '0, 4'd15);
    push_request(FUNC_READ_WRAP, '0, 4'd15);

    run_random_traffic();
    s_axis_tvalid <= 1'b0;

    while (tracker.owed_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (tracker.faults == 0 && tracker.owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
